// ----- sv/alarm_time_match_table_assert.svh -----
// Assertion macros for the alarm time match table.
// Used by alarm_time_match_table.sv; no other dependencies.
`ifndef ALARM_TIME_MATCH_TABLE_ASSERT_SVH
`define ALARM_TIME_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/atm_pkg.sv -----
// Shared types and constants for the alarm time match table.
// No dependencies; imported by atm_ctrl, alarm_time_match_table and the bench.
`default_nettype none

package atm_pkg;

    localparam int unsigned TABLE_ENTRIES = 8;
    localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned ENTRY_W = HOUR_W + MIN_W;
    localparam int unsigned COUNT_W = 4;

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPLY
    } t_state;

    // Scan sequencer to datapath
    typedef struct packed {
        logic             accept;   // command word taken this cycle
        logic             busy;
        logic             rd_en;    // entry read issued at rd_idx
        logic [IDX_W-1:0] rd_idx;
        logic             cmp_vld;  // read data for cmp_idx is on the RAM output
        logic [IDX_W-1:0] cmp_idx;
        logic             reply;    // result word strobe
    } t_scan_ctl;

endpackage

`default_nettype wire

// ----- sv/atm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module atm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/atm_ctrl.sv -----
// Scan sequencer: walks every table entry once per command word.
// Depends on atm_pkg.
`default_nettype none

module atm_ctrl
    import atm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output t_scan_ctl o_ctl
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             accept;
    logic             rd_en;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_REPLY;
            ST_REPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        accept = 1'b0;
        rd_en  = 1'b0;
        unique case (r_state)
            ST_IDLE:  accept = i_start;
            ST_SCAN:  rd_en  = 1'b1;
            ST_DRAIN: ;
            ST_REPLY: ;
            default:  ;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            n_idx = '0;
        end else if (rd_en && (r_idx != LAST_IDX)) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= rd_en;
            r_cmp_idx <= r_idx;
        end
    end

    assign o_ctl.accept  = accept;
    assign o_ctl.busy    = (r_state != ST_IDLE);
    assign o_ctl.rd_en   = rd_en;
    assign o_ctl.rd_idx  = r_idx;
    assign o_ctl.cmp_vld = r_cmp_vld;
    assign o_ctl.cmp_idx = r_cmp_idx;
    assign o_ctl.reply   = (r_state == ST_REPLY);

endmodule

`default_nettype wire

// ----- sv/alarm_time_match_table.sv -----
// Top level of the alarm time match table: valid flags, entry compare, results.
// Depends on atm_pkg, atm_ram, atm_ctrl and alarm_time_match_table_assert.svh.
//
//  channel   | handshake               | fields
//  ----------+-------------------------+---------------------------------------------
//  command   | start / busy            | i_opcode, i_alarm_hour, i_alarm_minute
//  result    | o_done (1-cycle strobe) | o_found, o_accepted, o_removed_count
//
// A command word is taken when start is high and busy is low. The sequencer
// then reads one entry per cycle from the time RAM (single read port,
// registered read) and compares it in the next cycle; after the last entry
// the DRAIN and REPLY states follow, and the result word is taken at the
// REPLY strobe. Busy falls in the cycle after the strobe, so the next word
// can go in then. Valid flags sit in flops and are cleared by the synchronous
// reset at once; the hour/minute RAM is not cleared. The result word is held
// for exactly one cycle and cannot stall.
`default_nettype none
`include "alarm_time_match_table_assert.svh"

module alarm_time_match_table
    import atm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [HOUR_W-1:0]  i_alarm_hour,
    input  wire logic [MIN_W-1:0]   i_alarm_minute,
    output logic                    o_done,
    output logic                    o_found,
    output logic                    o_accepted,
    output logic [COUNT_W-1:0]      o_removed_count
);

    t_scan_ctl ctl;

    // captured command word
    logic [OP_W-1:0]    r_op;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_minute;

    // per-entry valid flags and result accumulators
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_found, n_found;
    logic                     r_accepted, n_accepted;
    logic [COUNT_W-1:0]       r_count, n_count;

    logic [ENTRY_W-1:0] rd_entry;
    logic               entry_vld;
    logic               hit;
    logic               ram_we;

    atm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ctl   (ctl)
    );

    // hour/minute store; written only by add, read only during the scan
    atm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ctl.cmp_idx),
        .i_wdata ({r_hour, r_minute}),
        .i_re    (ctl.rd_en),
        .i_raddr (ctl.rd_idx),
        .o_rdata (rd_entry)
    );

    assign entry_vld = r_valid[ctl.cmp_idx];
    assign hit       = entry_vld && (rd_entry == {r_hour, r_minute});

    // Compare stage. The valid flag of cmp_idx is only touched here, and each
    // index comes up once per scan, so no read/write overlap on an entry.
    always_comb begin
        n_valid    = r_valid;
        n_found    = r_found;
        n_accepted = r_accepted;
        n_count    = r_count;
        ram_we     = 1'b0;
        if (ctl.accept) begin
            n_found    = 1'b0;
            n_accepted = (i_opcode != OP_ADD);   // add starts as not accepted
            n_count    = '0;
        end else if (ctl.cmp_vld) begin
            case (r_op)
                OP_SEARCH: begin
                    if (hit) n_found = 1'b1;
                end
                OP_ADD: begin
                    // first free entry wins; r_accepted marks it taken
                    if (!entry_vld && !r_accepted) begin
                        ram_we                = 1'b1;
                        n_valid[ctl.cmp_idx]  = 1'b1;
                        n_accepted            = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (hit) begin
                        n_valid[ctl.cmp_idx] = 1'b0;
                        if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
                    end
                end
                default: ;   // unused opcode: no change
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_op     <= i_opcode;
            r_hour   <= i_alarm_hour;
            r_minute <= i_alarm_minute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_found    <= 1'b0;
            r_accepted <= 1'b1;
            r_count    <= '0;
        end else begin
            r_valid    <= n_valid;
            r_found    <= n_found;
            r_accepted <= n_accepted;
            r_count    <= n_count;
        end
    end

    assign busy            = ctl.busy;
    assign o_done          = ctl.reply;
    assign o_found         = r_found;
    assign o_accepted      = r_accepted;
    assign o_removed_count = r_count;

    `ATM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")
    `ATM_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy still high after result")
    `ATM_ASSERT_NOW(a_write_add, i_clk, i_rst_n, ram_we, (r_op == OP_ADD) && !r_accepted, "RAM write outside an add")
    `ATM_ASSERT_NOW(a_found_search, i_clk, i_rst_n, o_done && o_found, r_op == OP_SEARCH, "found set on a non-search")
    `ATM_ASSERT_NOW(a_count_delete, i_clk, i_rst_n, o_done && (o_removed_count != '0), r_op == OP_DELETE, "count on a non-delete")

endmodule

`default_nettype wire

// ----- tb/alarm_time_match_table_tb.sv -----
// Self-checking bench for alarm_time_match_table: directed and random command words.
// Depends on atm_pkg and the alarm_time_match_table RTL; nothing else.
`default_nettype none

module alarm_time_match_table_tb;
    import atm_pkg::*;

    // Opcode value the block must treat as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int unsigned RANDOM_WORDS  = 1800;
    localparam int unsigned STALL_LIMIT   = 5000;  // cycles with no handshake at all
    localparam int unsigned SETTLE_CYCLES = 2 * (TABLE_ENTRIES + 3);

    // One result word as the block should report it
    typedef struct packed {
        logic               found;
        logic               accepted;
        logic [COUNT_W-1:0] removed;
    } t_alarm_reply;

    // Shadow copy of the alarm table plus the queue of replies still owed.
    class alarm_table_scoreboard;
        bit                slot_valid  [TABLE_ENTRIES];
        bit [HOUR_W-1:0]   slot_hour   [TABLE_ENTRIES];
        bit [MIN_W-1:0]    slot_minute [TABLE_ENTRIES];
        t_alarm_reply      replies_due [$];
        int unsigned       errors;

        function bit slot_hit(int k, logic [HOUR_W-1:0] hh, logic [MIN_W-1:0] mm);
            return slot_valid[k] && slot_hour[k] == hh && slot_minute[k] == mm;
        endfunction

        // Apply an accepted command word to the shadow table, queue its reply
        function void note_command(logic [OP_W-1:0] op, logic [HOUR_W-1:0] hh,
                                   logic [MIN_W-1:0] mm);
            t_alarm_reply r;
            r.found    = 1'b0;
            r.accepted = 1'b1;
            r.removed  = '0;
            case (op)
                OP_SEARCH: begin
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                        if (slot_hit(k, hh, mm)) r.found = 1'b1;
                end
                OP_ADD: begin
                    // lowest free slot wins, duplicates allowed
                    r.accepted = 1'b0;
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        if (!slot_valid[k] && !r.accepted) begin
                            slot_valid[k]  = 1'b1;
                            slot_hour[k]   = hh;
                            slot_minute[k] = mm;
                            r.accepted     = 1'b1;
                        end
                    end
                end
                OP_DELETE: begin
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        if (slot_hit(k, hh, mm)) begin
                            slot_valid[k] = 1'b0;
                            if (r.removed != COUNT_MAX) r.removed++;
                        end
                    end
                end
                default: ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_result(logic found, logic accepted, logic [COUNT_W-1:0] count);
            t_alarm_reply r;
            if (replies_due.size() == 0) begin
                $display("%0t: result word with nothing outstanding: found %b accepted %b count %0d",
                         $time, found, accepted, count);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (found !== r.found) begin
                $display("%0t: found mismatch: expected %b, got %b", $time, r.found, found);
                errors++;
            end
            if (accepted !== r.accepted) begin
                $display("%0t: accepted mismatch: expected %b, got %b",
                         $time, r.accepted, accepted);
                errors++;
            end
            if (count !== r.removed) begin
                $display("%0t: removed_count mismatch: expected %0d, got %0d",
                         $time, r.removed, count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_opcode;
    logic [HOUR_W-1:0]   i_alarm_hour;
    logic [MIN_W-1:0]    i_alarm_minute;
    logic                o_done;
    logic                o_found;
    logic                o_accepted;
    logic [COUNT_W-1:0]  o_removed_count;

    alarm_table_scoreboard sb = new;
    int unsigned           quiet_cycles;

    alarm_time_match_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_alarm_hour    (i_alarm_hour),
        .i_alarm_minute  (i_alarm_minute),
        .o_done          (o_done),
        .o_found         (o_found),
        .o_accepted      (o_accepted),
        .o_removed_count (o_removed_count)
    );

    always #10 i_clk = ~i_clk;

    // Monitor: everything is sampled at the rising edge, before the block's
    // own flops update, so the shadow table sees the same word the RTL takes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_command(i_opcode, i_alarm_hour, i_alarm_minute);
            if (o_done)
                sb.check_result(o_found, o_accepted, o_removed_count);
        end
    end

    // Watchdog: a hung handshake on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("alarm_time_match_table_tb failed");
            $finish;
        end
    end

    // Present one command word at the falling edge and hold it until taken.
    // Returns at the rising edge where the word went in, start still high.
    task automatic send_word(logic [OP_W-1:0] op, logic [HOUR_W-1:0] hh,
                             logic [MIN_W-1:0] mm);
        @(negedge i_clk);
        start          <= 1'b1;
        i_opcode       <= op;
        i_alarm_hour   <= hh;
        i_alarm_minute <= mm;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a number of cycles; gap of zero keeps the burst going
    task automatic sender_gap(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until the block has answered every word sent so far
    task automatic drain_replies();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Times mostly drawn from a small set so adds, searches and deletes collide;
    // the rest span the full field width, out-of-range hours and minutes too.
    task automatic pick_time(output logic [HOUR_W-1:0] hh, output logic [MIN_W-1:0] mm);
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
                0: begin hh = 5'd0;  mm = 6'd0;  end
                1: begin hh = 5'd23; mm = 6'd59; end
                2: begin hh = 5'd31; mm = 6'd63; end
                default: begin hh = 5'd12; mm = 6'd30; end
            endcase
        end else begin
            hh = HOUR_W'($urandom_range(0, 31));
            mm = MIN_W'($urandom_range(0, 63));
        end
    endtask

    // Alternate between fill-heavy and clear-heavy stretches so the table
    // swings between full and empty many times over the run.
    function automatic logic [OP_W-1:0] pick_op(int unsigned n);
        int unsigned r;
        bit          filling;
        r       = $urandom_range(0, 99);
        filling = ((n / 150) % 2) == 0;
        if (r < 5)                        return OP_UNUSED;
        if (r < (filling ? 60 : 25))      return OP_ADD;
        if (r < (filling ? 85 : 55))      return OP_SEARCH;
        return OP_DELETE;
    endfunction

    initial begin
        logic [OP_W-1:0]   op;
        logic [HOUR_W-1:0] hh;
        logic [MIN_W-1:0]  mm;
        int unsigned       burst_left;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_SEARCH;
        i_alarm_hour   = '0;
        i_alarm_minute = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, no-op opcode, fill with duplicates and
        // out-of-range times, add on a full table, multi-copy delete.
        send_word(OP_SEARCH, 5'd0, 6'd0);
        send_word(OP_DELETE, 5'd0, 6'd0);
        send_word(OP_UNUSED, 5'd31, 6'd63);
        send_word(OP_ADD, 5'd0, 6'd0);
        send_word(OP_ADD, 5'd0, 6'd0);
        send_word(OP_ADD, 5'd23, 6'd59);
        send_word(OP_ADD, 5'd31, 6'd63);
        send_word(OP_ADD, 5'd12, 6'd30);
        send_word(OP_ADD, 5'd5, 6'd7);
        send_word(OP_ADD, 5'd1, 6'd1);
        send_word(OP_ADD, 5'd2, 6'd2);
        send_word(OP_ADD, 5'd9, 6'd9);      // table full, must be refused
        send_word(OP_SEARCH, 5'd31, 6'd63);
        send_word(OP_SEARCH, 5'd31, 6'd62);
        send_word(OP_SEARCH, 5'd9, 6'd9);
        send_word(OP_DELETE, 5'd0, 6'd0);   // both copies go
        send_word(OP_ADD, 5'd9, 6'd9);      // lands in the lowest freed slot
        send_word(OP_ADD, 5'd4, 6'd4);
        send_word(OP_DELETE, 5'd31, 6'd63);
        send_word(OP_UNUSED, 5'd23, 6'd59);
        send_word(OP_SEARCH, 5'd23, 6'd59);
        send_word(OP_DELETE, 5'd23, 6'd58);
        drain_replies();

        // Random words in bursts with random gaps between them
        burst_left = 0;
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 19) == 0)
                    drain_replies();
                else
                    sender_gap($urandom_range(0, 20));
                burst_left = $urandom_range(1, 12);
            end
            op = pick_op(n);
            pick_time(hh, mm);
            send_word(op, hh, mm);
            burst_left--;
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("alarm_time_match_table_tb passed");
        else
            $display("alarm_time_match_table_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- alarm_time_match_table.f -----
+incdir+sv
sv/atm_pkg.sv
sv/atm_ram.sv
sv/atm_ctrl.sv
sv/alarm_time_match_table.sv
tb/alarm_time_match_table_tb.sv
